### hw/rtl/rdc_pkg.sv
package rdc_pkg;

   // widths of the working datapath and of the ports
   localparam int VALUE_BITS = 32;
   localparam int IN_VALUE_W = 32;
   localparam int RADIX_W    = 4;
   localparam int DIGIT_W    = 4;
   localparam int PROD_W     = VALUE_BITS + RADIX_W;

   // power stack holds every power below the top one
   localparam int STACK_AW    = $clog2(VALUE_BITS);
   localparam int STACK_DEPTH = 2 ** STACK_AW;

   // valid radix range
   localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(10);

   typedef logic [VALUE_BITS-1:0] value_type;

   // control from the sequencer to the power stack
   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } stack_ctrl_type;

endpackage

### hw/rtl/radix_digit_converter_core.sv
// a conversion grows the power of the radix first, then per digit subtracts it repeatedly and emits a beat
// throughput: one conversion at a time, the next request is taken after the last beat
// power growth uses the one radix multiplier, each digit the one compare-subtract unit
// a bad radix answers with one error beat in the cycle after the request
// reset: sequencer idle, no result beat pending, power stack storage left as is
module radix_digit_converter_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [rdc_pkg::IN_VALUE_W-1:0] req_value,
   input  logic [rdc_pkg::RADIX_W-1:0]  req_radix,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [rdc_pkg::DIGIT_W-1:0]  rsp_digit,
   output logic                         rsp_last,
   output logic                         rsp_error
);
   import rdc_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_GROW  = 2'd1;
   localparam logic [1:0] ST_DIGIT = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]          state_ff, state_in;
   value_type           rem_ff, rem_in;
   value_type           power_ff, power_in;
   logic [RADIX_W-1:0]  radix_ff, radix_in;
   logic [DIGIT_W-1:0]  digit_ff, digit_in;
   logic                last_ff, last_in;
   logic                error_ff, error_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [PROD_W-1:0]   product;
   logic                bad_radix;
   stack_ctrl_type      stk_ctrl;
   value_type           stk_top;
   logic                stk_empty;

   rdc_power_stack u_stack (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (stk_ctrl),
      .push_data (power_ff),
      .pop_data  (stk_top),
      .empty     (stk_empty)
   );

   // shared unit: next power of the radix
   assign product   = PROD_W'(power_ff) * PROD_W'(radix_ff);
   assign bad_radix = (req_radix < RADIX_MIN) || (req_radix > RADIX_MAX);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      power_in     = power_ff;
      radix_in     = radix_ff;
      digit_in     = digit_ff;
      last_in      = last_ff;
      error_in     = error_ff;
      rsp_valid_in = rsp_valid_ff;
      stk_ctrl     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (bad_radix) begin
                  digit_in     = '0;
                  last_in      = 1'b1;
                  error_in     = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_EMIT;
               end else begin
                  rem_in         = VALUE_BITS'(req_value);
                  power_in       = VALUE_BITS'(1);
                  radix_in       = req_radix;
                  error_in       = 1'b0;
                  stk_ctrl.clear = 1'b1;
                  state_in       = ST_GROW;
               end
            end
         end
         ST_GROW: begin
            // keep the power while the next one still fits in the value
            if (product <= PROD_W'(rem_ff)) begin
               stk_ctrl.push = 1'b1;
               power_in      = VALUE_BITS'(product);
            end else begin
               digit_in = '0;
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            // repeated subtract of the current power
            if (rem_ff >= power_ff) begin
               rem_in   = rem_ff - power_ff;
               digit_in = digit_ff + 1'b1;
            end else begin
               last_in      = stk_empty;
               stk_ctrl.pop = !stk_empty;
               rsp_valid_in = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  power_in = stk_top;
                  digit_in = '0;
                  state_in = ST_DIGIT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      power_ff <= power_in;
      radix_ff <= radix_in;
      digit_ff <= digit_in;
      last_ff  <= last_in;
      error_ff <= error_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_digit = digit_ff;
   assign rsp_last  = last_ff;
   assign rsp_error = error_ff;

endmodule

### hw/rtl/rdc_power_stack.sv
module rdc_power_stack (
   input  logic                   clock,
   input  logic                   reset,
   input  rdc_pkg::stack_ctrl_type ctrl,
   input  rdc_pkg::value_type     push_data,
   output rdc_pkg::value_type     pop_data,
   output logic                   empty
);
   import rdc_pkg::*;

   value_type             mem [STACK_DEPTH];
   logic [STACK_AW:0]     sp_ff;
   logic [STACK_AW:0]     sp_in;
   logic [STACK_AW-1:0]   rd_addr;
   value_type             pop_data_ff;

   assign empty   = (sp_ff == '0);
   assign rd_addr = STACK_AW'(sp_ff - 1'b1);

   // stack pointer update
   always_comb begin
      sp_in = sp_ff;
      priority if (ctrl.clear) begin
         sp_in = '0;
      end else if (ctrl.push) begin
         sp_in = sp_ff + 1'b1;
      end else if (ctrl.pop && !empty) begin
         sp_in = sp_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
   end

   // storage write on push, registered read on pop
   always_ff @(posedge clock) begin
      if (ctrl.push && !ctrl.clear) begin
         mem[sp_ff[STACK_AW-1:0]] <= push_data;
      end
      if (ctrl.pop && !empty) begin
         pop_data_ff <= mem[rd_addr];
      end
   end

   assign pop_data = pop_data_ff;

endmodule
